// ===== hdl/egcd_pkg.sv =====
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended gcd block: payload structs, controller
// states and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package egcd_pkg;

	localparam int FIELD_W = 32;

	typedef struct packed {
		logic signed [FIELD_W-1:0] first_operand;
		logic signed [FIELD_W-1:0] second_operand;
	} egcd_in_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] divisor;
		logic signed [FIELD_W-1:0] coef_first;
		logic signed [FIELD_W-1:0] coef_second;
	} egcd_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SETUP,
		ST_DIV,
		ST_UPDATE,
		ST_DONE
	} egcd_state_t;

	typedef struct packed {
		logic load;
		logic setup;
		logic step;
		logic update;
	} egcd_cmd_t;

	typedef struct packed {
		logic y_zero;
	} egcd_sts_t;

endpackage

// ===== hdl/egcd_ctrl.sv =====
// ----------------------------------------------------------------------------
// egcd_ctrl
// Controller for the extended gcd block: sequences the euclid iterations and
// counts the bit steps of each restoring division.
// ----------------------------------------------------------------------------
module egcd_ctrl #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	output logic                done,
	output egcd_pkg::egcd_cmd_t cmd,
	input  egcd_pkg::egcd_sts_t sts
);
	import egcd_pkg::*;

	localparam int CNT_W = $clog2(WIDTH);

	egcd_state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic last_step;

	assign last_step = (cnt_q == CNT_W'(WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SETUP) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:   if (start) state_d = ST_CHECK;
			ST_CHECK:  state_d = sts.y_zero ? ST_DONE : ST_SETUP;
			ST_SETUP:  state_d = ST_DIV;
			ST_DIV:    if (last_step) state_d = ST_UPDATE;
			ST_UPDATE: state_d = ST_CHECK;
			ST_DONE:   state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			ST_SETUP:  cmd.setup  = 1'b1;
			ST_DIV:    cmd.step   = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			ST_DONE:   done       = 1'b1;
			ST_CHECK: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hdl/egcd_dp.sv =====
// ----------------------------------------------------------------------------
// egcd_dp
// Datapath for the extended gcd block: remainder pair, bezout coefficient
// pairs and a bit-serial restoring divider that also forms q*a and q*b.
// ----------------------------------------------------------------------------
module egcd_dp #(
	parameter int WIDTH = 32
) (
	input  logic                 clk,
	input  egcd_pkg::egcd_in_t   operands,
	input  egcd_pkg::egcd_cmd_t  cmd,
	output egcd_pkg::egcd_sts_t  sts,
	output egcd_pkg::egcd_out_t  result
);
	import egcd_pkg::*;

	logic [WIDTH-1:0] x_q, y_q, pa_q, a_q, pb_q, b_q;
	logic [WIDTH-1:0] num_q, md_q, rem_q, ma_q, mb_q;
	logic             qneg_q, rneg_q;
	logic [WIDTH-1:0] in_x, in_y;
	logic [FIELD_W-1:0] out_g, out_a, out_b;
	logic [WIDTH:0]   trial, diff;
	logic             qbit;
	logic [WIDTH-1:0] rem_next, rem_signed;

	// field to WIDTH bits and back, sign extending where widening
	if (WIDTH > FIELD_W) begin : g_wide
		assign in_x  = {{(WIDTH-FIELD_W){operands.first_operand[FIELD_W-1]}},
			operands.first_operand};
		assign in_y  = {{(WIDTH-FIELD_W){operands.second_operand[FIELD_W-1]}},
			operands.second_operand};
		assign out_g = x_q[FIELD_W-1:0];
		assign out_a = pa_q[FIELD_W-1:0];
		assign out_b = pb_q[FIELD_W-1:0];
	end else if (WIDTH == FIELD_W) begin : g_same
		assign in_x  = operands.first_operand;
		assign in_y  = operands.second_operand;
		assign out_g = x_q;
		assign out_a = pa_q;
		assign out_b = pb_q;
	end else begin : g_narrow
		assign in_x  = operands.first_operand[WIDTH-1:0];
		assign in_y  = operands.second_operand[WIDTH-1:0];
		assign out_g = {{(FIELD_W-WIDTH){x_q[WIDTH-1]}}, x_q};
		assign out_a = {{(FIELD_W-WIDTH){pa_q[WIDTH-1]}}, pa_q};
		assign out_b = {{(FIELD_W-WIDTH){pb_q[WIDTH-1]}}, pb_q};
	end

	assign result.divisor     = out_g;
	assign result.coef_first  = out_a;
	assign result.coef_second = out_b;
	assign sts.y_zero         = (y_q == '0);

	// one restoring step: bring in the next dividend bit, try the subtract
	assign trial      = {rem_q, num_q[WIDTH-1]};
	assign diff       = trial - {1'b0, md_q};
	assign qbit       = ~diff[WIDTH];
	assign rem_next   = qbit ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
	assign rem_signed = rneg_q ? (~rem_q + 1'b1) : rem_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q  <= in_x;
			y_q  <= in_y;
			pa_q <= WIDTH'(1);
			a_q  <= '0;
			pb_q <= '0;
			b_q  <= WIDTH'(1);
		end
		if (cmd.setup) begin
			// magnitude of the most negative value reads as 2^(WIDTH-1) unsigned
			num_q  <= x_q[WIDTH-1] ? (~x_q + 1'b1) : x_q;
			md_q   <= y_q[WIDTH-1] ? (~y_q + 1'b1) : y_q;
			qneg_q <= x_q[WIDTH-1] ^ y_q[WIDTH-1];
			rneg_q <= x_q[WIDTH-1];
			rem_q  <= '0;
			ma_q   <= '0;
			mb_q   <= '0;
		end
		if (cmd.step) begin
			num_q <= {num_q[WIDTH-2:0], 1'b0};
			rem_q <= rem_next;
			// horner accumulation of |q|*a and |q|*b, msb first
			ma_q  <= {ma_q[WIDTH-2:0], 1'b0} + (qbit ? a_q : '0);
			mb_q  <= {mb_q[WIDTH-2:0], 1'b0} + (qbit ? b_q : '0);
		end
		if (cmd.update) begin
			a_q  <= qneg_q ? (pa_q + ma_q) : (pa_q - ma_q);
			pa_q <= a_q;
			b_q  <= qneg_q ? (pb_q + mb_q) : (pb_q - mb_q);
			pb_q <= b_q;
			x_q  <= y_q;
			y_q  <= rem_signed;
		end
	end

endmodule

// ===== hdl/extended_gcd.sv =====
// ----------------------------------------------------------------------------
// extended_gcd
// Extended euclidean algorithm: gcd of two signed operands with bezout
// coefficients, truncating division, two's complement wrap at WIDTH bits.
//
//   channel   handshake        payload
//   -------   --------------   ---------------------------------------
//   command   start / busy     operands  (first_operand, second_operand)
//   result    done strobe      result    (divisor, coef_first, coef_second)
//
// each euclid iteration runs check, setup, the bit-serial restoring divider
// (one quotient bit per cycle) and update, in that order.
// start is taken only while busy is low; done is high for one cycle with
// the result and cannot be stalled. reset clears the controller only.
// ----------------------------------------------------------------------------
module extended_gcd #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  egcd_pkg::egcd_in_t  operands,
	output logic                done,
	output egcd_pkg::egcd_out_t result
);
	import egcd_pkg::*;

	egcd_cmd_t cmd;
	egcd_sts_t sts;

	egcd_ctrl #(.WIDTH(WIDTH)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	egcd_dp #(.WIDTH(WIDTH)) u_dp (
		.clk      (clk),
		.operands (operands),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

endmodule

// ===== bench/extended_gcd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_checker
// Watches the command and result channels of the extended gcd block. For
// every accepted command it computes the gcd and bezout coefficients with
// truncating division at WIDTH bits and queues them. Each result strobe is
// compared field by field against the oldest queued entry.
// ----------------------------------------------------------------------------
module extended_gcd_checker #(
	parameter int WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  egcd_pkg::egcd_in_t  operands,
	input  logic                done,
	input  egcd_pkg::egcd_out_t result,
	output int                  errors,
	output int                  outstanding
);
	import egcd_pkg::*;

	typedef logic [WIDTH-1:0] word_t;

	egcd_out_t expected_results[$];

	// 32-bit field to WIDTH bits, sign-extended first
	function automatic word_t widen(logic [FIELD_W-1:0] f);
		logic signed [63:0] ext;
		ext = $signed(f);
		return ext[WIDTH-1:0];
	endfunction

	// WIDTH bits back to the 32-bit field, sign-extended first
	function automatic logic [FIELD_W-1:0] narrow(word_t v);
		logic signed [WIDTH-1:0] s;
		logic signed [63:0] ext;
		s = v;
		ext = s;
		return ext[FIELD_W-1:0];
	endfunction

	function automatic egcd_out_t bezout(egcd_in_t op);
		word_t x, y, q, r, t, pa, a, pb, b, mn, md, mq, mr;
		logic sn, sd;
		egcd_out_t res;
		x = widen(op.first_operand);
		y = widen(op.second_operand);
		pa = word_t'(1);
		a = '0;
		pb = '0;
		b = word_t'(1);
		while (y != 0) begin
			// divide magnitudes; the most negative value keeps its own pattern
			sn = x[WIDTH-1];
			sd = y[WIDTH-1];
			mn = sn ? -x : x;
			md = sd ? -y : y;
			mq = mn / md;
			mr = mn % md;
			q = (sn != sd) ? -mq : mq;
			r = sn ? -mr : mr;
			t = a;
			a = pa - q * a;
			pa = t;
			t = b;
			b = pb - q * b;
			pb = t;
			x = y;
			y = r;
		end
		res.divisor = narrow(x);
		res.coef_first = narrow(pa);
		res.coef_second = narrow(pb);
		return res;
	endfunction

	task automatic check_field(input string name, input logic signed [FIELD_W-1:0] want,
			input logic signed [FIELD_W-1:0] got);
		if (want !== got) begin
			errors++;
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : watch
		egcd_out_t want;
		if (!arst_n) begin
			errors = 0;
			outstanding = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					errors++;
					$display("%0t ns: result with no transaction pending, actual %0d %0d %0d",
						$time, result.divisor, result.coef_first, result.coef_second);
				end else begin
					want = expected_results.pop_front();
					check_field("divisor", want.divisor, result.divisor);
					check_field("coef_first", want.coef_first, result.coef_first);
					check_field("coef_second", want.coef_second, result.coef_second);
				end
			end
			if (start && !busy)
				expected_results = {expected_results, bezout(operands)};
			outstanding = expected_results.size();
		end
	end

endmodule

// ===== bench/extended_gcd_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// extended_gcd_tb
// Stimulus for the extended gcd block: a directed set of edge operands,
// then random pairs (full range, small, extremes, shared factors, zero
// divisors) under three command idling profiles. A checker beside the
// block predicts and compares every result.
// ----------------------------------------------------------------------------
module extended_gcd_tb;
	import egcd_pkg::*;

	localparam int WIDTH = 32;
	localparam int RANDOM_ITEMS = 400;
	localparam logic signed [FIELD_W-1:0] S_MIN = 32'sh8000_0000;
	localparam logic signed [FIELD_W-1:0] S_MAX = 32'sh7fff_ffff;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      start = 1'b0;
	logic      busy;
	logic      done;
	egcd_in_t  operands = '0;
	egcd_out_t result;
	int        errors;
	int        outstanding;
	int        idle_pct = 13;

	extended_gcd #(.WIDTH(WIDTH)) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.operands (operands),
		.done     (done),
		.result   (result)
	);

	extended_gcd_checker #(.WIDTH(WIDTH)) u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operands    (operands),
		.done        (done),
		.result      (result),
		.errors      (errors),
		.outstanding (outstanding)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// one command transaction; busy only moves at rising edges, so a low busy
	// seen at the falling edge means the next rising edge takes the command
	task automatic issue(input logic signed [FIELD_W-1:0] x, input logic signed [FIELD_W-1:0] y);
		egcd_in_t cmd;
		cmd.first_operand = x;
		cmd.second_operand = y;
		@(negedge clk);
		while (busy || ($urandom_range(99) < idle_pct)) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		operands <= cmd;
		@(posedge clk);
	endtask

	function automatic logic signed [FIELD_W-1:0] pick_operand();
		logic [FIELD_W-1:0] v;
		v = $urandom;
		case ($urandom_range(5))
			0, 1: return v;
			2: return $urandom_range(2000) - 1000;
			3: begin
				case ($urandom_range(4))
					0: return S_MIN;
					1: return S_MAX;
					2: return 0;
					3: return 1;
					default: return -1;
				endcase
			end
			default: begin
				v = v >> $urandom_range(31);
				return $urandom_range(1) ? -v : v;
			end
		endcase
	endfunction

	initial begin : stimulus
		int g;
		int k1;
		int k2;
		logic signed [FIELD_W-1:0] x;
		logic signed [FIELD_W-1:0] y;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		// zero divisor, wrap on most negative by minus one, extremes, signs
		issue(0, 0);
		issue(5, 0);
		issue(-7, 0);
		issue(0, 5);
		issue(S_MIN, 0);
		issue(0, S_MIN);
		issue(S_MIN, -1);
		issue(-1, S_MIN);
		issue(S_MIN, S_MIN);
		issue(S_MAX, S_MAX);
		issue(S_MAX, S_MIN);
		issue(S_MIN, S_MAX);
		issue(S_MAX, -1);
		issue(S_MIN, 2);
		issue(S_MIN, 1);
		issue(1, S_MAX);
		issue(12, 18);
		issue(-12, 18);
		issue(12, -18);
		issue(-12, -18);
		issue(240, 46);
		issue(-1, -1);
		// consecutive fibonacci numbers give the longest chain
		issue(1836311903, 1134903170);
		issue(-1134903170, 1836311903);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 3)
				idle_pct = 75;
			else if (i == 2 * RANDOM_ITEMS / 3)
				idle_pct = 0;
			case ($urandom_range(9))
				0, 1: begin
					// shared factor so the gcd is not trivially one
					g = $urandom_range(5000, 1);
					k1 = $urandom_range(400000) - 200000;
					k2 = $urandom_range(400000) - 200000;
					x = g * k1;
					y = g * k2;
				end
				2: begin
					x = pick_operand();
					y = 0;
				end
				default: begin
					x = pick_operand();
					y = pick_operand();
				end
			endcase
			issue(x, y);
		end

		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (100) @(negedge clk);
		if (errors == 0 && outstanding == 0)
			$display("extended_gcd verification clean");
		else
			$display("extended_gcd verification failed");
		$finish;
	end

	initial begin : watchdog
		#(30_000_000);
		$display("extended_gcd verification failed");
		$finish;
	end

endmodule

// ===== files.f =====
hdl/egcd_pkg.sv
hdl/egcd_ctrl.sv
hdl/egcd_dp.sv
hdl/extended_gcd.sv
bench/extended_gcd_checker.sv
bench/extended_gcd_tb.sv
